// ===== src/bundle_duplicate_filter_table_defines.svh =====
// Assertion helpers used by the sequencer RTL of the duplicate filter table.
`ifndef BUNDLE_DUPLICATE_FILTER_TABLE_DEFINES_SVH
`define BUNDLE_DUPLICATE_FILTER_TABLE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BDFT_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDFT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bdft_pkg.sv =====
`default_nettype none

package bdft_pkg;

    localparam int unsigned FIELD_W = 32;
    localparam int unsigned STEP_W  = 16;
    localparam int unsigned COUNT_W = 5;

    localparam logic [STEP_W-1:0]  AGE_STEP_RESET = 16'd5;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = 5'd31;

    typedef enum logic [1:0] {
        ACT_CHECK  = 2'd0,
        ACT_INSERT = 2'd1,
        ACT_TICK   = 2'd2
    } action_t;

    typedef enum logic [2:0] {
        ST_ABSENT    = 3'd0,
        ST_DUPLICATE = 3'd1,
        ST_STORED    = 3'd2,
        ST_FULL      = 3'd3,
        ST_TICK      = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH,
        S_DONE
    } state_t;

    // One table word; source sits in the low bits.
    typedef struct packed {
        logic [FIELD_W-1:0] lifetime;
        logic [FIELD_W-1:0] fragment;
        logic [FIELD_W-1:0] sequence_num;
        logic [FIELD_W-1:0] source;
    } entry_t;

    // One request as captured from the input beat.
    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] source;
        logic [FIELD_W-1:0] sequence_num;
        logic [FIELD_W-1:0] fragment;
        logic [FIELD_W-1:0] lifetime;
    } item_t;

    // Result handed from the sequencer to the output register.
    typedef struct packed {
        logic [2:0]         status;
        logic [COUNT_W-1:0] expired_count;
    } result_t;

endpackage

`default_nettype wire

// ===== src/bdft_ram.sv =====
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module bdft_ram #(
    parameter int unsigned WIDTH = 128,
    parameter int unsigned DEPTH = 16,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             aclk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/bdft_ctrl.sv =====
`default_nettype none

// Sequencer: sweeps the table one entry per cycle, read-modify-write.
module bdft_ctrl #(
    parameter int unsigned ENTRIES = 16,
    localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1,
    localparam int unsigned CW = $clog2(ENTRIES + 1)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bdft_pkg::item_t               in_item,
    input  wire logic [bdft_pkg::STEP_W-1:0]   age_step,
    output logic                               res_valid,
    input  wire logic                          res_ready,
    output bdft_pkg::result_t                  res
);

    bdft_pkg::state_t state_reg, state_next;
    bdft_pkg::item_t  item_reg;
    logic [CW-1:0]    scan_cnt_reg, scan_cnt_next;
    logic             pend_reg, pend_next;
    logic [AW-1:0]    pend_idx_reg, pend_idx_next;
    logic             hit_reg, hit_next;
    logic             free_found_reg, free_found_next;
    logic [AW-1:0]    free_idx_reg, free_idx_next;
    logic [bdft_pkg::COUNT_W-1:0] expired_reg, expired_next;
    logic [2:0]       status_reg, status_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    logic                  rd_en;
    logic [AW-1:0]         rd_addr;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    bdft_pkg::entry_t      wr_data;
    bdft_pkg::entry_t      rd_data;
    logic [$bits(bdft_pkg::entry_t)-1:0] rd_word;
    logic                  in_fire;
    logic                  match;
    logic                  expire;
    logic [bdft_pkg::FIELD_W-1:0] step_ext;

    bdft_ram #(
        .WIDTH($bits(bdft_pkg::entry_t)),
        .DEPTH(ENTRIES)
    ) u_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_addr),
        .wdata(wr_data),
        .re   (rd_en),
        .raddr(rd_addr),
        .rdata(rd_word)
    );

    assign rd_data  = bdft_pkg::entry_t'(rd_word);
    assign in_ready = (state_reg == bdft_pkg::S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign step_ext = {{(bdft_pkg::FIELD_W - bdft_pkg::STEP_W){1'b0}}, age_step};

    // Compare of the word returning from the RAM
    assign match = valid_reg[pend_idx_reg]
                && (rd_data.source == item_reg.source)
                && (rd_data.sequence_num == item_reg.sequence_num)
                && (rd_data.fragment == item_reg.fragment);
    assign expire = (rd_data.lifetime <= step_ext);

    // Request capture
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            item_reg <= in_item;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= bdft_pkg::S_IDLE;
            scan_cnt_reg   <= '0;
            pend_reg       <= 1'b0;
            pend_idx_reg   <= '0;
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            free_idx_reg   <= '0;
            expired_reg    <= '0;
            status_reg     <= bdft_pkg::ST_ABSENT;
            valid_reg      <= '0;
        end else begin
            state_reg      <= state_next;
            scan_cnt_reg   <= scan_cnt_next;
            pend_reg       <= pend_next;
            pend_idx_reg   <= pend_idx_next;
            hit_reg        <= hit_next;
            free_found_reg <= free_found_next;
            free_idx_reg   <= free_idx_next;
            expired_reg    <= expired_next;
            status_reg     <= status_next;
            valid_reg      <= valid_next;
        end
    end

    // Next state, RAM port control and result
    always_comb begin
        state_next      = state_reg;
        scan_cnt_next   = scan_cnt_reg;
        pend_next       = 1'b0;
        pend_idx_next   = pend_idx_reg;
        hit_next        = hit_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        expired_next    = expired_reg;
        status_next     = status_reg;
        valid_next      = valid_reg;
        rd_en           = 1'b0;
        rd_addr         = scan_cnt_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_addr         = pend_idx_reg;
        wr_data         = rd_data;
        res_valid       = 1'b0;
        res.status        = status_reg;
        res.expired_count = expired_reg;

        case (state_reg)
            bdft_pkg::S_IDLE: begin
                if (in_fire) begin
                    scan_cnt_next   = '0;
                    hit_next        = 1'b0;
                    free_found_next = 1'b0;
                    expired_next    = '0;
                    state_next      = bdft_pkg::S_SCAN;
                end
            end
            bdft_pkg::S_SCAN: begin
                // issue the next read
                if (scan_cnt_reg < CW'(ENTRIES)) begin
                    rd_en         = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = scan_cnt_reg[AW-1:0];
                    scan_cnt_next = scan_cnt_reg + CW'(1);
                end else begin
                    state_next = bdft_pkg::S_FINISH;
                end
                // handle the word read last cycle; write-back goes to a
                // different entry than the read issued in the same cycle
                if (pend_reg) begin
                    if (match) begin
                        hit_next = 1'b1;
                    end
                    if (!valid_reg[pend_idx_reg] && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = pend_idx_reg;
                    end
                    if ((item_reg.action == bdft_pkg::ACT_TICK) &&
                        valid_reg[pend_idx_reg]) begin
                        if (expire) begin
                            valid_next[pend_idx_reg] = 1'b0;
                            if (expired_reg != bdft_pkg::COUNT_MAX) begin
                                expired_next = expired_reg + bdft_pkg::COUNT_W'(1);
                            end
                        end else begin
                            wr_en            = 1'b1;
                            wr_data.lifetime = rd_data.lifetime - step_ext;
                        end
                    end
                end
            end
            bdft_pkg::S_FINISH: begin
                wr_addr               = free_idx_reg;
                wr_data.source        = item_reg.source;
                wr_data.sequence_num  = item_reg.sequence_num;
                wr_data.fragment      = item_reg.fragment;
                wr_data.lifetime      = item_reg.lifetime;
                state_next            = bdft_pkg::S_DONE;
                case (item_reg.action)
                    bdft_pkg::ACT_CHECK: begin
                        status_next = hit_reg ? bdft_pkg::ST_DUPLICATE
                                              : bdft_pkg::ST_ABSENT;
                    end
                    bdft_pkg::ACT_INSERT: begin
                        if (hit_reg) begin
                            status_next = bdft_pkg::ST_DUPLICATE;
                        end else if (free_found_reg) begin
                            wr_en                    = 1'b1;
                            valid_next[free_idx_reg] = 1'b1;
                            status_next              = bdft_pkg::ST_STORED;
                        end else begin
                            status_next = bdft_pkg::ST_FULL;
                        end
                    end
                    bdft_pkg::ACT_TICK: begin
                        status_next = bdft_pkg::ST_TICK;
                    end
                    default: begin
                        status_next = bdft_pkg::ST_ABSENT;
                    end
                endcase
            end
            bdft_pkg::S_DONE: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = bdft_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = bdft_pkg::S_IDLE;
            end
        endcase
    end

    `include "bundle_duplicate_filter_table_defines.svh"

    `BDFT_ASSERT_NOW(a_no_rw_collision, aclk, aresetn, wr_en && rd_en, wr_addr != rd_addr, "read and write hit the same entry")
    `BDFT_ASSERT_NOW(a_scan_bound, aclk, aresetn, 1'b1, scan_cnt_reg <= CW'(ENTRIES), "scan counter past table end")
    `BDFT_ASSERT_NOW(a_count_only_tick, aclk, aresetn, res_valid && (item_reg.action != bdft_pkg::ACT_TICK), res.expired_count == '0, "expired count on a non-tick")
    `BDFT_ASSERT_NEXT(a_accept_scans, aclk, aresetn, in_fire, (state_reg == bdft_pkg::S_SCAN) && (scan_cnt_reg == '0), "accepted beat did not start a sweep")
    `BDFT_ASSERT_NOW(a_insert_grows, aclk, aresetn, (state_reg == bdft_pkg::S_FINISH) && wr_en, !valid_reg[free_idx_reg], "insert into an occupied slot")

endmodule

`default_nettype wire

// ===== src/bundle_duplicate_filter_table.sv =====
// Channel  | Dir | Beat contents (low bit first)
// ---------+-----+----------------------------------------------------------
// s_       | in  | tuser: action; tdata: source, sequence, fragment, lifetime
// m_       | out | tuser: status; tdata: expired_count, zero pad
// cfg_     | in  | data: age_step
//
// Each beat runs through the idle accept, one read per table entry through the
// single RAM read port, a drain step, a finish step and the result hand-over.
// Reset (aresetn low, synchronous) clears the valid bits and control state; RAM
// contents are not cleared. A result waits in the output register while the next
// beat is accepted; m_tready low only stalls a sweep once its own result is ready
// to leave.
`default_nettype none

module bundle_duplicate_filter_table #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,  // source, sequence_number, fragment_offset, lifetime_in
    input  wire logic [1:0]   s_tuser,  // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [7:0]        m_tdata,  // expired_count, zeros
    output logic [2:0]        m_tuser,  // status
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data  // age_step
);

    logic [bdft_pkg::STEP_W-1:0] age_step_reg;
    bdft_pkg::item_t   item;
    bdft_pkg::result_t res;
    bdft_pkg::result_t out_reg;
    logic              res_valid;
    logic              res_ready;
    logic              out_valid_reg;

    // Input beat unpack
    assign item.action       = s_tuser;
    assign item.source       = s_tdata[31:0];
    assign item.sequence_num = s_tdata[63:32];
    assign item.fragment     = s_tdata[95:64];
    assign item.lifetime     = s_tdata[127:96];

    // Age step register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            age_step_reg <= bdft_pkg::AGE_STEP_RESET;
        end else if (cfg_valid && cfg_ready) begin
            age_step_reg <= cfg_data;
        end
    end

    bdft_ctrl #(
        .ENTRIES(ENTRIES)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_item  (item),
        .age_step (age_step_reg),
        .res_valid(res_valid),
        .res_ready(res_ready),
        .res      (res)
    );

    // Output register
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (res_ready) begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ready && res_valid) begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.status;
    assign m_tdata  = {{(8 - bdft_pkg::COUNT_W){1'b0}}, out_reg.expired_count};

endmodule

`default_nettype wire

// ===== sim/bundle_duplicate_filter_table_tb.sv =====
`default_nettype none

module bundle_duplicate_filter_table_tb;
    import bdft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TABLE_DEPTH = 16;
    localparam int unsigned POOL_SIZE   = 20;
    localparam int unsigned PHASES      = 6;
    localparam int unsigned PHASE_ITEMS = 105;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 320;
    localparam int unsigned SETTLE      = 48;
    localparam int unsigned REPORT_MAX  = 20;
    // action code outside the decoded set; the block must answer it as absent
    localparam logic [1:0]  ACT_UNUSED  = 2'd3;

    typedef struct packed {
        logic [2:0]         status;
        logic [COUNT_W-1:0] expired;
    } outcome_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] src;
        logic [31:0] seq_num;
        logic [31:0] frag;
        logic [31:0] life;
        bit          typed;
        outcome_t    want;
    } script_row_t;

    logic         aclk;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata   = '0;  // source, sequence_number, fragment_offset, lifetime_in
    logic [1:0]   s_tuser   = '0;  // action
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [7:0]   m_tdata;         // expired_count, zeros
    logic [2:0]   m_tuser;         // status
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [15:0]  cfg_data  = '0;  // age_step

    bundle_duplicate_filter_table #(
        .ENTRIES(TABLE_DEPTH)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    // Shadow copy of the filter table and its aging step
    bit          shadow_valid [TABLE_DEPTH];
    logic [31:0] shadow_src   [TABLE_DEPTH];
    logic [31:0] shadow_seq   [TABLE_DEPTH];
    logic [31:0] shadow_frag  [TABLE_DEPTH];
    logic [31:0] shadow_life  [TABLE_DEPTH];
    logic [15:0] shadow_step;

    // Identities reused by the random traffic so that hits and duplicates occur
    logic [31:0] pool_src  [POOL_SIZE];
    logic [31:0] pool_seq  [POOL_SIZE];
    logic [31:0] pool_frag [POOL_SIZE];

    outcome_t    outcomes_due [$];
    outcome_t    head_outcome;
    int unsigned mismatches   = 0;
    int unsigned burst_left   = 0;
    bit          no_gaps      = 1'b0;
    int unsigned hold_req     = 0;
    int unsigned hold_left    = 0;
    int unsigned stall_mode   = 0;
    int unsigned mode_left    = 0;
    int unsigned stall_phase  = 0;
    int unsigned quiet_cycles = 0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%0t ns: %s mismatch, got %0h want %0h", $time, what, got, want);
    endtask

    // Apply one request to the shadow table and return the answer it earns
    function automatic outcome_t apply_to_shadow(input logic [1:0] act,
                                                 input logic [31:0] src, seq_num,
                                                 input logic [31:0] frag, life);
        outcome_t res;
        bit       held;
        int       slot;
        res.status  = ST_ABSENT;
        res.expired = '0;
        held = 1'b0;
        slot = -1;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            if (shadow_valid[k] && shadow_src[k] == src && shadow_seq[k] == seq_num &&
                shadow_frag[k] == frag)
                held = 1'b1;
        end
        case (act)
            ACT_CHECK: res.status = held ? ST_DUPLICATE : ST_ABSENT;
            ACT_INSERT: begin
                if (held) begin
                    res.status = ST_DUPLICATE;
                end else begin
                    res.status = ST_FULL;
                    for (int k = 0; k < TABLE_DEPTH; k++) begin
                        if (!shadow_valid[k] && slot < 0)
                            slot = k;
                    end
                    if (slot >= 0) begin
                        shadow_valid[slot] = 1'b1;
                        shadow_src[slot]   = src;
                        shadow_seq[slot]   = seq_num;
                        shadow_frag[slot]  = frag;
                        shadow_life[slot]  = life;
                        res.status         = ST_STORED;
                    end
                end
            end
            ACT_TICK: begin
                // every slot is visited, freeing one never ends the sweep
                for (int k = 0; k < TABLE_DEPTH; k++) begin
                    if (shadow_valid[k]) begin
                        if (shadow_life[k] <= {16'h0000, shadow_step}) begin
                            shadow_valid[k] = 1'b0;
                            if (res.expired != COUNT_MAX)
                                res.expired++;
                        end else begin
                            shadow_life[k] = shadow_life[k] - {16'h0000, shadow_step};
                        end
                    end
                end
                res.status = ST_TICK;
            end
            default: ;
        endcase
        return res;
    endfunction

    // Lifetimes clustered around the step, plus full-range values
    function automatic logic [31:0] pick_lifetime();
        logic [31:0] step_wide;
        step_wide = {16'h0000, shadow_step};
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return step_wide;
            2: return step_wide + 32'd1;
            3: return $urandom_range(0, 4 * step_wide + 4);
            4: return $urandom;
            default: return 32'hFFFF_FFFF;
        endcase
    endfunction

    // Offer one input beat in bursts with random gaps; predict on acceptance
    task automatic offer_beat(input logic [1:0] act, input logic [31:0] src, seq_num,
                              input logic [31:0] frag, life, input bit typed,
                              input outcome_t typed_want);
        int unsigned gap;
        outcome_t    predicted;
        if (burst_left == 0) begin
            gap = (no_gaps || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            burst_left = $urandom_range(1, 12);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {life, frag, seq_num, src};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predicted = apply_to_shadow(act, src, seq_num, frag, life);
        outcomes_due.push_back(typed ? typed_want : predicted);
        burst_left--;
    endtask

    // Stop offering and wait for every outstanding answer
    task automatic pause_sender();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        while (outcomes_due.size() != 0) @(posedge aclk);
    endtask

    task automatic write_age_step(input logic [15:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid  <= 1'b0;
        shadow_step = value;
    endtask

    // New identity pool; some entries differ from an earlier one by a single bit
    task automatic refresh_pool();
        int unsigned j;
        int unsigned b;
        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_src[i]  = $urandom;
            pool_seq[i]  = $urandom;
            pool_frag[i] = $urandom;
            if (i > 0 && $urandom_range(0, 3) == 0) begin
                j = $urandom_range(0, i - 1);
                b = $urandom_range(0, 31);
                pool_src[i]  = pool_src[j];
                pool_seq[i]  = pool_seq[j];
                pool_frag[i] = pool_frag[j];
                case ($urandom_range(0, 2))
                    0: pool_src[i][b]  = ~pool_src[i][b];
                    1: pool_seq[i][b]  = ~pool_seq[i][b];
                    default: pool_frag[i][b] = ~pool_frag[i][b];
                endcase
            end
        end
    endtask

    task automatic send_random_item();
        logic [1:0]  act;
        logic [31:0] src;
        logic [31:0] seq_num;
        logic [31:0] frag;
        int unsigned roll;
        int unsigned pick;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            act = ACT_INSERT;
        else if (roll < 80)
            act = ACT_CHECK;
        else if (roll < 94)
            act = ACT_TICK;
        else
            act = ACT_UNUSED;
        if ($urandom_range(0, 6) == 0) begin
            src     = $urandom;
            seq_num = $urandom;
            frag    = $urandom;
        end else begin
            pick    = $urandom_range(0, POOL_SIZE - 1);
            src     = pool_src[pick];
            seq_num = pool_seq[pick];
            frag    = pool_frag[pick];
        end
        offer_beat(act, src, seq_num, frag, pick_lifetime(), 1'b0, '0);
    endtask

    // Stimulus: directed script, then random phases at several step settings
    initial begin
        script_row_t script [17];
        logic [15:0] step_plan [PHASES];
        int unsigned items;
        for (int k = 0; k < TABLE_DEPTH; k++)
            shadow_valid[k] = 1'b0;
        shadow_step = AGE_STEP_RESET;
        step_plan = '{16'd5, 16'd1, 16'd0, 16'hFFFF, 16'd0, 16'd5};
        step_plan[4] = 16'($urandom_range(2, 65534));
        script = '{
            // empty table, extremes and the unused code
            '{ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_ABSENT, 5'd0}},
            '{ACT_CHECK,  '1, '1, '1, '1, 1'b1, '{ST_ABSENT, 5'd0}},
            '{ACT_UNUSED, '1, '1, '1, '1, 1'b1, '{ST_ABSENT, 5'd0}},
            '{ACT_TICK,   '1, '1, '1, '1, 1'b1, '{ST_TICK, 5'd0}},
            // zero lifetime stored, then the all-ones identity
            '{ACT_INSERT, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1, '{ST_STORED, 5'd0}},
            '{ACT_INSERT, '1, '1, '1, '1, 1'b1, '{ST_STORED, 5'd0}},
            '{ACT_INSERT, 32'h0, 32'h0, 32'h0, 32'h7, 1'b1, '{ST_DUPLICATE, 5'd0}},
            '{ACT_CHECK,  '1, '1, '1, 32'h0, 1'b1, '{ST_DUPLICATE, 5'd0}},
            // near miss in the fragment only
            '{ACT_CHECK,  '1, '1, 32'hFFFF_FFFE, 32'h0, 1'b0, '0},
            // lifetime equal to the step and one above it
            '{ACT_INSERT, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 32'h0F0F_0F0F, 32'd5, 1'b0, '0},
            '{ACT_INSERT, 32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hF0F0_F0F0, 32'd6, 1'b0, '0},
            '{ACT_TICK,   32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
            '{ACT_CHECK,  32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
            '{ACT_CHECK,  32'h5A5A_5A5A, 32'hA5A5_A5A5, 32'hF0F0_F0F0, 32'h0, 1'b0, '0},
            // freed slot is reused lowest first
            '{ACT_INSERT, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0, 32'd100, 1'b0, '0},
            '{ACT_TICK,   32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0},
            '{ACT_UNUSED, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (script[i])
            offer_beat(script[i].action, script[i].src, script[i].seq_num, script[i].frag,
                       script[i].life, script[i].typed, script[i].want);
        pause_sender();

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase != 0)
                write_age_step(step_plan[phase]);
            refresh_pool();
            items = 0;
            while (items < PHASE_ITEMS) begin
                if (phase == 2 && items == 0) begin
                    // receiver holds off while the sender keeps pushing
                    hold_req = HOLD_CYCLES;
                    no_gaps  = 1'b1;
                    repeat (12) send_random_item();
                    no_gaps  = 1'b0;
                    items += 12;
                end else if ($urandom_range(0, 11) == 0) begin
                    // overfill with short-lived identities, then age them out
                    repeat (18)
                        offer_beat(ACT_INSERT, $urandom, $urandom, $urandom,
                                   $urandom_range(0, shadow_step), 1'b0, '0);
                    offer_beat(ACT_TICK, $urandom, $urandom, $urandom, $urandom, 1'b0, '0);
                    items += 19;
                end else begin
                    send_random_item();
                    items++;
                end
            end
            pause_sender();
        end

        repeat (SETTLE) @(posedge aclk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Result side: compare each beat, then drive the stall pattern
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (outcomes_due.size() == 0) begin
                report_mismatch("unexpected result status", m_tuser, 0);
            end else begin
                head_outcome = outcomes_due.pop_front();
                if (m_tuser !== head_outcome.status)
                    report_mismatch("status", m_tuser, head_outcome.status);
                if (m_tdata !== {3'b000, head_outcome.expired})
                    report_mismatch("expired_count", m_tdata, head_outcome.expired);
            end
        end
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(30, 200);
        end
        mode_left--;
        stall_phase++;
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else begin
            case (stall_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= (stall_phase % 4 == 0);
                default: m_tready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // Watchdog on cycles without any accepted beat
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule

`default_nettype wire

// ===== bundle_duplicate_filter_table.f =====
+incdir+src
src/bdft_pkg.sv
src/bdft_ram.sv
src/bdft_ctrl.sv
src/bundle_duplicate_filter_table.sv
sim/bundle_duplicate_filter_table_tb.sv
